/* src/raid0_stripe_splitter_top_defines.svh */
// assertion macros for the raid0 stripe splitter checker
// expects clk and rst_n to be visible where a macro is used
`ifndef RAID0_STRIPE_SPLITTER_TOP_DEFINES_SVH
`define RAID0_STRIPE_SPLITTER_TOP_DEFINES_SVH

// same-cycle implication
`define R0S_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// next-cycle implication
`define R0S_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

/* src/r0split_pkg.sv */
// shared types and constants for the raid0 stripe splitter
// no dependencies
package r0split_pkg;

    localparam int OFFSET_W   = 44;
    localparam int LENGTH_W   = 18;
    localparam int STRIPE_W   = 25;
    localparam int NDEV_W     = 5;
    localparam int MIDX_W     = 4;
    localparam int QUOT_W     = 32;
    localparam int POS_W      = 45;
    localparam int PROD_W     = QUOT_W + STRIPE_W;
    localparam int CNT_W      = 6;
    localparam int LONG_STEPS = 44;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    localparam logic [STRIPE_W-1:0] STRIPE_MIN = 25'd4096;
    localparam logic [STRIPE_W-1:0] STRIPE_MAX = 25'd16777216;
    localparam logic [LENGTH_W-1:0] LEN_MAX    = 18'd258048;

    localparam logic REG_STRIPE_SIZE = 1'b0;
    localparam logic REG_NUM_DEVICES = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_D,
        ST_DL_GO,
        ST_DL_WAIT,
        ST_DS_GO,
        ST_DS_WAIT,
        ST_MUL_BASE,
        ST_BASE_LD,
        ST_EMIT
    } r0split_state_t;

    typedef struct packed {
        logic load_req;
        logic mul_go;
        logic mul_sel_base;
        logic div_go_long;
        logic div_go_short;
        logic capture_q;
        logic capture_div;
        logic load_base;
        logic emit;
    } r0split_cmd_t;

    typedef struct packed {
        logic req_zero;
        logic div_busy;
        logic out_free;
        logic last;
    } r0split_sts_t;

endpackage

/* src/r0split_cfg.sv */
// configuration registers with apb write and read, and range clamping
// depends on r0split_pkg
module r0split_cfg #(
    parameter int MAX_DEVICES = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [r0split_pkg::ADDR_W-1:0]        paddr,
    input  logic [r0split_pkg::DATA_W-1:0]        pwdata,
    output logic [r0split_pkg::DATA_W-1:0]        prdata,
    output logic                                  pready,
    output logic [r0split_pkg::STRIPE_W-1:0]      ss_eff,
    output logic [$clog2(MAX_DEVICES+1)-1:0]      nd_eff
);

    localparam int ND_W = $clog2(MAX_DEVICES + 1);

    logic [r0split_pkg::STRIPE_W-1:0] stripe_size_reg, stripe_size_next;
    logic [r0split_pkg::NDEV_W-1:0]   num_devices_reg, num_devices_next;
    logic                             wr_en;
    logic [31:0]                      nd_wide;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        stripe_size_next = stripe_size_reg;
        num_devices_next = num_devices_reg;
        if (wr_en)
        begin
            case (paddr[2])
                r0split_pkg::REG_STRIPE_SIZE:
                    stripe_size_next = pwdata[r0split_pkg::STRIPE_W-1:0];
                r0split_pkg::REG_NUM_DEVICES:
                    num_devices_next = pwdata[r0split_pkg::NDEV_W-1:0];
                default:
                    stripe_size_next = stripe_size_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stripe_size_reg <= 25'd4096;
            num_devices_reg <= 5'd1;
        end
        else
        begin
            stripe_size_reg <= stripe_size_next;
            num_devices_reg <= num_devices_next;
        end
    end

    always_comb
    begin
        case (paddr[2])
            r0split_pkg::REG_STRIPE_SIZE:
                prdata = {7'd0, stripe_size_reg};
            r0split_pkg::REG_NUM_DEVICES:
                prdata = {27'd0, num_devices_reg};
            default:
                prdata = '0;
        endcase
    end

    // clamp to the supported ranges
    always_comb
    begin
        if (stripe_size_reg < r0split_pkg::STRIPE_MIN)
            ss_eff = r0split_pkg::STRIPE_MIN;
        else if (stripe_size_reg > r0split_pkg::STRIPE_MAX)
            ss_eff = r0split_pkg::STRIPE_MAX;
        else
            ss_eff = stripe_size_reg;
    end

    always_comb
    begin
        if (num_devices_reg == '0)
            nd_wide = 32'd1;
        else if (32'(num_devices_reg) > 32'(MAX_DEVICES))
            nd_wide = 32'(MAX_DEVICES);
        else
            nd_wide = 32'(num_devices_reg);
    end

    assign nd_eff = nd_wide[ND_W-1:0];

endmodule

/* src/r0split_div.sv */
// radix-2 restoring divider, one quotient bit per cycle
// long mode divides a 44-bit offset, short mode a remainder for SHORT_STEPS quotient bits
// depends on r0split_pkg
module r0split_div #(
    parameter int DVS_W       = 32,
    parameter int SHORT_STEPS = 4
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  go_long,
    input  logic                                  go_short,
    input  logic [r0split_pkg::OFFSET_W-1:0]      dividend,
    input  logic [DVS_W-1:0]                      short_in,
    input  logic [DVS_W-1:0]                      divisor,
    output logic                                  busy,
    output logic [r0split_pkg::OFFSET_W-1:0]      quotient,
    output logic [DVS_W-1:0]                      remainder
);

    localparam int OW = r0split_pkg::OFFSET_W;

    logic [DVS_W-1:0]               p_reg, p_next;
    logic [OW-1:0]                  q_reg, q_next;
    logic [DVS_W-1:0]               dvs_reg, dvs_next;
    logic [r0split_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DVS_W:0]                 shifted;
    logic [DVS_W+1:0]               diff;
    logic                           ge;

    assign shifted = {p_reg, q_reg[OW-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dvs_reg};
    assign ge      = !diff[DVS_W+1];

    always_comb
    begin
        p_next   = p_reg;
        q_next   = q_reg;
        dvs_next = dvs_reg;
        cnt_next = cnt_reg;
        if (go_long)
        begin
            p_next   = '0;
            q_next   = dividend;
            dvs_next = divisor;
            cnt_next = r0split_pkg::CNT_W'(r0split_pkg::LONG_STEPS);
        end
        else if (go_short)
        begin
            p_next   = DVS_W'(short_in >> SHORT_STEPS);
            q_next   = OW'(short_in) << (OW - SHORT_STEPS);
            dvs_next = divisor;
            cnt_next = r0split_pkg::CNT_W'(SHORT_STEPS);
        end
        else if (cnt_reg != '0)
        begin
            p_next   = ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
            q_next   = {q_reg[OW-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        p_reg   <= p_next;
        q_reg   <= q_next;
        dvs_reg <= dvs_next;
    end

    assign busy      = (cnt_reg != '0);
    assign quotient  = q_reg;
    assign remainder = p_reg;

endmodule

/* src/r0split_dp.sv */
// datapath: request registers, shared multiplier, divider and chunk output register
// depends on r0split_pkg and r0split_div
module r0split_dp #(
    parameter int MAX_DEVICES = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  r0split_pkg::r0split_cmd_t             cmd,
    output r0split_pkg::r0split_sts_t             sts,
    input  logic [r0split_pkg::STRIPE_W-1:0]      ss_eff,
    input  logic [$clog2(MAX_DEVICES+1)-1:0]      nd_eff,
    input  logic [r0split_pkg::OFFSET_W-1:0]      request_offset,
    input  logic [r0split_pkg::LENGTH_W-1:0]      request_length,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [r0split_pkg::MIDX_W-1:0]        member_index,
    output logic [r0split_pkg::OFFSET_W-1:0]      member_offset,
    output logic [r0split_pkg::LENGTH_W-1:0]      chunk_length,
    output logic                                  last_chunk
);

    localparam int ND_W  = $clog2(MAX_DEVICES + 1);
    localparam int IDX_W = $clog2(MAX_DEVICES);
    localparam int DVS_W = r0split_pkg::STRIPE_W + ND_W;
    localparam int SW    = r0split_pkg::STRIPE_W;
    localparam int LW    = r0split_pkg::LENGTH_W;
    localparam int OW    = r0split_pkg::OFFSET_W;
    localparam int PW    = r0split_pkg::POS_W;

    logic [OW-1:0]                     pos_reg;
    logic [LW-1:0]                     left_reg;
    logic [r0split_pkg::QUOT_W-1:0]    q_reg;
    logic [IDX_W-1:0]                  idx_reg;
    logic [SW-1:0]                     within_reg;
    logic [PW-1:0]                     base_reg;
    logic [r0split_pkg::PROD_W-1:0]    prod_reg;

    logic                              out_valid_reg, out_valid_next;
    logic [r0split_pkg::MIDX_W-1:0]    member_index_reg;
    logic [OW-1:0]                     member_offset_reg;
    logic [LW-1:0]                     chunk_length_reg;
    logic                              last_chunk_reg;

    logic [r0split_pkg::QUOT_W-1:0]    mul_a;
    logic [DVS_W-1:0]                  div_divisor;
    logic                              div_busy;
    logic [OW-1:0]                     div_quot;
    logic [DVS_W-1:0]                  div_rem;

    logic [SW-1:0]                     room;
    logic [LW-1:0]                     len;
    logic [LW-1:0]                     left_after;
    logic [PW-1:0]                     chunk_pos;
    logic                              wrap;
    logic [IDX_W+3:0]                  idx_ext;
    logic                              out_free;

    // shared multiplier: stripe times device count, then row times stripe
    assign mul_a = cmd.mul_sel_base ? q_reg : r0split_pkg::QUOT_W'(nd_eff);

    always_ff @(posedge clk)
    begin
        if (cmd.mul_go)
            prod_reg <= r0split_pkg::PROD_W'(mul_a) * r0split_pkg::PROD_W'(ss_eff);
    end

    assign div_divisor = cmd.div_go_short ? DVS_W'(ss_eff) : prod_reg[DVS_W-1:0];

    r0split_div #(
        .DVS_W       (DVS_W),
        .SHORT_STEPS (IDX_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .go_long   (cmd.div_go_long),
        .go_short  (cmd.div_go_short),
        .dividend  (pos_reg),
        .short_in  (div_rem),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // chunk arithmetic
    assign room       = ss_eff - within_reg;
    assign len        = (SW'(left_reg) < room) ? left_reg : room[LW-1:0];
    assign left_after = left_reg - len;
    assign chunk_pos  = base_reg + PW'(within_reg);
    assign wrap       = (ND_W'(idx_reg) == (nd_eff - ND_W'(1)));
    assign out_free   = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            pos_reg  <= request_offset;
            left_reg <= (request_length > r0split_pkg::LEN_MAX) ?
                        r0split_pkg::LEN_MAX : request_length;
        end
        else if (cmd.emit)
            left_reg <= left_after;

        if (cmd.capture_q)
            q_reg <= div_quot[r0split_pkg::QUOT_W-1:0];

        if (cmd.capture_div)
        begin
            idx_reg    <= div_quot[IDX_W-1:0];
            within_reg <= div_rem[SW-1:0];
        end
        else if (cmd.emit)
        begin
            within_reg <= '0;
            idx_reg    <= wrap ? '0 : idx_reg + 1'b1;
        end

        if (cmd.load_base)
            base_reg <= prod_reg[PW-1:0];
        else if (cmd.emit && wrap)
            base_reg <= base_reg + PW'(ss_eff);
    end

    // output register
    assign idx_ext = {4'd0, idx_reg};

    always_comb
    begin
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            member_index_reg  <= idx_ext[r0split_pkg::MIDX_W-1:0];
            member_offset_reg <= chunk_pos[OW-1:0];
            chunk_length_reg  <= len;
            last_chunk_reg    <= (left_after == '0);
        end
    end

    assign out_valid     = out_valid_reg;
    assign member_index  = member_index_reg;
    assign member_offset = member_offset_reg;
    assign chunk_length  = chunk_length_reg;
    assign last_chunk    = last_chunk_reg;

    assign sts.req_zero = (request_length == '0);
    assign sts.div_busy = div_busy;
    assign sts.out_free = out_free;
    assign sts.last     = (left_after == '0);

endmodule

/* src/r0split_ctrl.sv */
// sequencing state machine for the stripe splitter
// depends on r0split_pkg
module r0split_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  r0split_pkg::r0split_sts_t     sts,
    output r0split_pkg::r0split_cmd_t     cmd
);

    r0split_pkg::r0split_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= r0split_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            r0split_pkg::ST_IDLE:
                if (in_valid && !sts.req_zero)
                    state_next = r0split_pkg::ST_MUL_D;
            r0split_pkg::ST_MUL_D:
                state_next = r0split_pkg::ST_DL_GO;
            r0split_pkg::ST_DL_GO:
                state_next = r0split_pkg::ST_DL_WAIT;
            r0split_pkg::ST_DL_WAIT:
                if (!sts.div_busy)
                    state_next = r0split_pkg::ST_DS_GO;
            r0split_pkg::ST_DS_GO:
                state_next = r0split_pkg::ST_DS_WAIT;
            r0split_pkg::ST_DS_WAIT:
                if (!sts.div_busy)
                    state_next = r0split_pkg::ST_MUL_BASE;
            r0split_pkg::ST_MUL_BASE:
                state_next = r0split_pkg::ST_BASE_LD;
            r0split_pkg::ST_BASE_LD:
                state_next = r0split_pkg::ST_EMIT;
            r0split_pkg::ST_EMIT:
                if (sts.out_free && sts.last)
                    state_next = r0split_pkg::ST_IDLE;
            default:
                state_next = r0split_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            r0split_pkg::ST_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.load_req = in_valid;
            end
            r0split_pkg::ST_MUL_D:
                cmd.mul_go = 1'b1;
            r0split_pkg::ST_DL_GO:
                cmd.div_go_long = 1'b1;
            r0split_pkg::ST_DS_GO:
            begin
                cmd.div_go_short = 1'b1;
                cmd.capture_q    = 1'b1;
            end
            r0split_pkg::ST_MUL_BASE:
            begin
                cmd.mul_go       = 1'b1;
                cmd.mul_sel_base = 1'b1;
                cmd.capture_div  = 1'b1;
            end
            r0split_pkg::ST_BASE_LD:
                cmd.load_base = 1'b1;
            r0split_pkg::ST_EMIT:
                cmd.emit = sts.out_free;
            default:
                cmd = '0;
        endcase
    end

endmodule

/* src/raid0_stripe_splitter_top.sv */
// raid0 stripe splitter top level
// depends on r0split_pkg, r0split_cfg, r0split_dp, r0split_ctrl
//
// one request (request_offset, request_length) is taken on the input channel
// (in_valid/in_ready) and split into chunks on the output channel
// (out_valid/out_ready), one chunk per stripe touched, in ascending order,
// last_chunk set on the final one. a zero-length request gives no chunks.
// stripe_size sits at address 0 and num_devices at address 4 of the apb port.
// the first chunk follows the request transfer after a multiply, a 44-step
// divide of the offset by stripe_size * num_devices, a clog2(MAX_DEVICES)-step
// divide of the remainder by stripe_size, then a multiply for the member row
// offset.
// further chunks follow one per cycle while out_ready is high.
// a new request is taken once the last chunk is in the output register.
// if the receiver stalls the output register holds its chunk and the
// sequencer waits. reset empties the output register, returns to idle and
// sets stripe_size to 4096 and num_devices to 1.
module raid0_stripe_splitter_top #(
    parameter int MAX_DEVICES = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [r0split_pkg::ADDR_W-1:0]        paddr,
    input  logic [r0split_pkg::DATA_W-1:0]        pwdata,
    output logic [r0split_pkg::DATA_W-1:0]        prdata,
    output logic                                  pready,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [r0split_pkg::OFFSET_W-1:0]      request_offset,
    input  logic [r0split_pkg::LENGTH_W-1:0]      request_length,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [r0split_pkg::MIDX_W-1:0]        member_index,
    output logic [r0split_pkg::OFFSET_W-1:0]      member_offset,
    output logic [r0split_pkg::LENGTH_W-1:0]      chunk_length,
    output logic                                  last_chunk
);

    localparam int ND_W = $clog2(MAX_DEVICES + 1);

    logic [r0split_pkg::STRIPE_W-1:0] ss_eff;
    logic [ND_W-1:0]                  nd_eff;
    r0split_pkg::r0split_cmd_t        cmd;
    r0split_pkg::r0split_sts_t        sts;

    r0split_cfg #(
        .MAX_DEVICES (MAX_DEVICES)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .ss_eff  (ss_eff),
        .nd_eff  (nd_eff)
    );

    r0split_dp #(
        .MAX_DEVICES (MAX_DEVICES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .ss_eff         (ss_eff),
        .nd_eff         (nd_eff),
        .request_offset (request_offset),
        .request_length (request_length),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .member_index   (member_index),
        .member_offset  (member_offset),
        .chunk_length   (chunk_length),
        .last_chunk     (last_chunk)
    );

    r0split_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

endmodule

/* src/r0split_chk.sv */
// port-level checker for the raid0 stripe splitter, bound to the top level
// depends on raid0_stripe_splitter_top_defines.svh and r0split_pkg
`include "raid0_stripe_splitter_top_defines.svh"

module r0split_chk (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  in_valid,
    input logic                                  in_ready,
    input logic [r0split_pkg::LENGTH_W-1:0]      request_length,
    input logic                                  out_valid,
    input logic                                  out_ready,
    input logic [r0split_pkg::OFFSET_W-1:0]      member_offset,
    input logic [r0split_pkg::LENGTH_W-1:0]      chunk_length,
    input logic                                  last_chunk
);

    // a stalled chunk keeps its offset
    `R0S_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(member_offset))

    // chunk length within its bounds
    `R0S_ASSERT_IMP(a_len_range, out_valid, chunk_length != '0 && chunk_length <= r0split_pkg::LEN_MAX)

    // no new request while a request is still being split
    `R0S_ASSERT_IMP(a_busy_no_req, out_valid && !last_chunk, !in_ready)

    // a non-empty request takes the splitter out of idle
    `R0S_ASSERT_NXT(a_req_busy, in_valid && in_ready && request_length != '0, !in_ready)

endmodule

bind raid0_stripe_splitter_top r0split_chk u_chk (.*);

/* bench/raid0_stripe_splitter_top_tb.sv */
// self-checking bench for raid0_stripe_splitter_top: random and directed requests
// with chunk prediction, stripe and member settings changed over the apb port
// depends on r0split_pkg and raid0_stripe_splitter_top
module raid0_stripe_splitter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DEVICES     = 16;
    localparam int N_PHASES        = 8;
    localparam int ITEMS_PER_PHASE = 58;
    localparam int SETTLE_CYCLES   = 100;
    localparam int LONG_HOLD       = 500;

    localparam logic [r0split_pkg::ADDR_W-1:0] ADDR_STRIPE =
        {r0split_pkg::REG_STRIPE_SIZE, 2'b00};
    localparam logic [r0split_pkg::ADDR_W-1:0] ADDR_NDEV   =
        {r0split_pkg::REG_NUM_DEVICES, 2'b00};

    typedef struct packed {
        logic [r0split_pkg::MIDX_W-1:0]   member_index;
        logic [r0split_pkg::OFFSET_W-1:0] member_offset;
        logic [r0split_pkg::LENGTH_W-1:0] chunk_length;
        logic                             last_chunk;
    } chunk_t;

    class chunk_scoreboard;
        logic [r0split_pkg::STRIPE_W-1:0] stripe_reg;
        logic [r0split_pkg::NDEV_W-1:0]   ndev_reg;
        chunk_t                           chunks_due[$];
        int                               mismatches;
        int                               chunks_seen;

        function new();
            stripe_reg  = 25'd4096;
            ndev_reg    = 5'd1;
            mismatches  = 0;
            chunks_seen = 0;
        endfunction

        function void write_reg(logic [r0split_pkg::ADDR_W-1:0] addr,
                                logic [r0split_pkg::DATA_W-1:0] data);
            if (addr == ADDR_STRIPE)
                stripe_reg = data[r0split_pkg::STRIPE_W-1:0];
            else if (addr == ADDR_NDEV)
                ndev_reg = data[r0split_pkg::NDEV_W-1:0];
        endfunction

        function void split_request(logic [r0split_pkg::OFFSET_W-1:0] off,
                                    logic [r0split_pkg::LENGTH_W-1:0] len);
            longint unsigned ss;
            longint unsigned nd;
            longint unsigned pos;
            longint unsigned left;
            longint unsigned stripe_no;
            longint unsigned in_stripe;
            longint unsigned span;
            chunk_t          c;
            ss = stripe_reg;
            if (ss < r0split_pkg::STRIPE_MIN)
                ss = r0split_pkg::STRIPE_MIN;
            else if (ss > r0split_pkg::STRIPE_MAX)
                ss = r0split_pkg::STRIPE_MAX;
            nd = ndev_reg;
            if (nd == 0)
                nd = 1;
            else if (nd > MAX_DEVICES)
                nd = MAX_DEVICES;
            pos  = off;
            left = (len > r0split_pkg::LEN_MAX) ? r0split_pkg::LEN_MAX : len;
            while (left > 0)
            begin
                stripe_no = pos / ss;
                in_stripe = pos % ss;
                span      = ss - in_stripe;
                if (span > left)
                    span = left;
                c.member_index  = r0split_pkg::MIDX_W'(stripe_no % nd);
                c.member_offset = r0split_pkg::OFFSET_W'((stripe_no / nd) * ss + in_stripe);
                c.chunk_length  = r0split_pkg::LENGTH_W'(span);
                left -= span;
                pos  += span;
                c.last_chunk    = (left == 0);
                chunks_due.push_back(c);
            end
        endfunction

        function void check_chunk(chunk_t got);
            chunk_t want;
            if (chunks_due.size() == 0)
            begin
                $error("unexpected chunk: member_index %0d member_offset 0x%0h chunk_length %0d",
                       got.member_index, got.member_offset, got.chunk_length);
                mismatches++;
                return;
            end
            want = chunks_due.pop_front();
            chunks_seen++;
            if (got.member_index !== want.member_index)
            begin
                $error("member_index: expected %0d, actual %0d",
                       want.member_index, got.member_index);
                mismatches++;
            end
            if (got.member_offset !== want.member_offset)
            begin
                $error("member_offset: expected 0x%0h, actual 0x%0h",
                       want.member_offset, got.member_offset);
                mismatches++;
            end
            if (got.chunk_length !== want.chunk_length)
            begin
                $error("chunk_length: expected %0d, actual %0d",
                       want.chunk_length, got.chunk_length);
                mismatches++;
            end
            if (got.last_chunk !== want.last_chunk)
            begin
                $error("last_chunk: expected %0b, actual %0b",
                       want.last_chunk, got.last_chunk);
                mismatches++;
            end
        endfunction
    endclass

    logic                             clk;
    logic                             rst_n          = 1'b0;
    logic                             psel           = 1'b0;
    logic                             penable        = 1'b0;
    logic                             pwrite         = 1'b0;
    logic [r0split_pkg::ADDR_W-1:0]   paddr          = '0;
    logic [r0split_pkg::DATA_W-1:0]   pwdata         = '0;
    logic [r0split_pkg::DATA_W-1:0]   prdata;
    logic                             pready;
    logic                             in_valid       = 1'b0;
    logic                             in_ready;
    logic [r0split_pkg::OFFSET_W-1:0] request_offset = '0;
    logic [r0split_pkg::LENGTH_W-1:0] request_length = '0;
    logic                             out_valid;
    logic                             out_ready      = 1'b0;
    logic [r0split_pkg::MIDX_W-1:0]   member_index;
    logic [r0split_pkg::OFFSET_W-1:0] member_offset;
    logic [r0split_pkg::LENGTH_W-1:0] chunk_length;
    logic                             last_chunk;

    bit                               idle_on = 1'b1;
    chunk_scoreboard                  sb = new();

    raid0_stripe_splitter_top #(
        .MAX_DEVICES (MAX_DEVICES)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .request_offset (request_offset),
        .request_length (request_length),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .member_index   (member_index),
        .member_offset  (member_offset),
        .chunk_length   (chunk_length),
        .last_chunk     (last_chunk)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic apb_write(input logic [r0split_pkg::ADDR_W-1:0] addr,
                             input logic [r0split_pkg::DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_reg(addr, data);
        @(negedge clk);
    endtask

    task automatic send_request(input logic [r0split_pkg::OFFSET_W-1:0] off,
                                input logic [r0split_pkg::LENGTH_W-1:0] len);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        in_valid       <= 1'b1;
        request_offset <= off;
        request_length <= len;
        do
            @(posedge clk);
        while (!in_ready);
        sb.split_request(off, len);
        @(negedge clk);
    endtask

    // drain every chunk, then give a zero-length request time to finish
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.chunks_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin : sink
        int  hold_left;
        bit  pressure_done;
        hold_left     = 0;
        pressure_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
                hold_left--;
            else if (!pressure_done && sb.chunks_seen >= 40)
            begin
                hold_left     = LONG_HOLD;
                pressure_done = 1'b1;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
                hold_left = $urandom_range(1, 14);
            out_ready <= (hold_left == 0);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_chunk({member_index, member_offset, chunk_length, last_chunk});
    end

    initial
    begin : stimulus
        logic [r0split_pkg::OFFSET_W-1:0] off;
        logic [r0split_pkg::LENGTH_W-1:0] len;
        logic [r0split_pkg::DATA_W-1:0]   stripe_val;
        logic [r0split_pkg::DATA_W-1:0]   ndev_val;

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: 4096-byte stripes on one member
        send_request(44'h0, 18'd0);
        send_request(44'h0, 18'd1);
        send_request(44'h0, 18'd4096);
        send_request(44'd4095, 18'd2);
        send_request(44'h0, r0split_pkg::LEN_MAX);
        send_request(44'h1, r0split_pkg::LEN_MAX);
        send_request(44'd100, 18'h3FFFF);
        send_request(44'hFFF_FFFF_FFFF, r0split_pkg::LEN_MAX);
        send_request(44'hFFF_FFFF_F001, 18'd8192);
        send_request(44'hFFF_FFFF_FFFF, 18'd1);
        send_request(44'h555_5555_5555, 18'h2AAAA);
        send_request(44'hAAA_AAAA_AAAA, 18'h15555);
        send_request(44'h123_4567_8000, 18'd0);

        for (int p = 0; p < N_PHASES; p++)
        begin
            settle();
            case (p)
                0:       begin stripe_val = 32'd4096;       ndev_val = 32'd16; end
                1:       begin stripe_val = 32'd0;          ndev_val = 32'd0;  end
                2:       begin stripe_val = 32'd16777216;   ndev_val = 32'd7;  end
                3:       begin stripe_val = 32'hFFFF_FFFF;  ndev_val = 32'hFFFF_FFFF; end
                4:       begin stripe_val = 32'd4095;       ndev_val = 32'd17; end
                5:
                begin
                    stripe_val = $urandom_range(4096, 65536);
                    ndev_val   = $urandom_range(1, 16);
                end
                6:       begin stripe_val = 32'd12288;      ndev_val = 32'd5;  end
                default:
                begin
                    stripe_val = $urandom();
                    ndev_val   = $urandom();
                end
            endcase
            apb_write(ADDR_STRIPE, stripe_val);
            apb_write(ADDR_NDEV, ndev_val);
            idle_on = (p != 3) && (p != N_PHASES - 1);

            repeat (ITEMS_PER_PHASE)
            begin
                case ($urandom_range(0, 7))
                    0:       off = '1 - r0split_pkg::OFFSET_W'($urandom_range(0, 300000));
                    1:
                    begin
                        off        = r0split_pkg::OFFSET_W'({$urandom(), $urandom()});
                        off[11:0]  = '0;
                    end
                    2:       off = r0split_pkg::OFFSET_W'($urandom_range(0, 1 << 20));
                    default: off = r0split_pkg::OFFSET_W'({$urandom(), $urandom()});
                endcase
                case ($urandom_range(0, 9))
                    0:       len = '0;
                    1:       len = r0split_pkg::LENGTH_W'(
                                 $urandom_range(int'(r0split_pkg::LEN_MAX) + 1,
                                                (1 << r0split_pkg::LENGTH_W) - 1));
                    2, 3:    len = r0split_pkg::LENGTH_W'(
                                 $urandom_range(1, int'(r0split_pkg::LEN_MAX)));
                    4:       len = r0split_pkg::LENGTH_W'($urandom_range(1, 8) * 4096);
                    default: len = r0split_pkg::LENGTH_W'($urandom_range(1, 20000));
                endcase
                send_request(off, len);
            end
        end
        settle();

        if (sb.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
